// File: rtl/gmpl_pkg.sv
// Shared constants, types and helpers of the grid monotone path length block.
package gmpl_pkg;

   localparam int MAX_COLS = 64;
   localparam int MAX_ROWS = 64;

   localparam int VAL_W = 32;
   localparam int LEN_W = 7;
   localparam int CFG_W = 7;
   localparam int CSR_IDX_W = 1;

   localparam int COL_W = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
   localparam int ROW_W = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;

   localparam logic [LEN_W-1:0] LEN_MAX = '1;
   localparam logic [LEN_W-1:0] LEN_ONE = LEN_W'(1);

   localparam logic [CSR_IDX_W-1:0] CSR_ROWS_IN_USE = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_COLS_IN_USE = CSR_IDX_W'(1);

   localparam logic [CFG_W-1:0] CFG_MAX_ROWS = CFG_W'(MAX_ROWS);
   localparam logic [CFG_W-1:0] CFG_MAX_COLS = CFG_W'(MAX_COLS);

   typedef struct packed {
      logic signed [VAL_W-1:0] value;
      logic [LEN_W-1:0]        length;
   } row_entry_type;

   // Position of one cell, passed from the sequencer to the compute stage.
   typedef struct packed {
      logic [COL_W-1:0] slot;
      logic             has_left;
      logic             has_above;
      logic             grid_end;
   } cell_pos_type;

   function automatic logic [LEN_W-1:0] inc_sat(input logic [LEN_W-1:0] len);
      inc_sat = (len == LEN_MAX) ? LEN_MAX : len + LEN_ONE;
   endfunction

   function automatic logic [CFG_W-1:0] clamp_size(input logic [CFG_W-1:0] reg_val,
                                                   input logic [CFG_W-1:0] max_val);
      if (reg_val == '0) begin
         clamp_size = CFG_W'(1);
      end else if (reg_val > max_val) begin
         clamp_size = max_val;
      end else begin
         clamp_size = reg_val;
      end
   endfunction

endpackage

// File: rtl/gmpl_if.sv
// Valid/ready channel interfaces for grid cells and path length results.
interface gmpl_req_if;
   logic                                 valid;
   logic                                 ready;
   logic signed [gmpl_pkg::VAL_W-1:0]    cell_value;

   modport source (output valid, output cell_value, input ready);
   modport sink   (input valid, input cell_value, output ready);
endinterface

interface gmpl_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [gmpl_pkg::LEN_W-1:0]    longest_path;

   modport source (output valid, output longest_path, input ready);
   modport sink   (input valid, input longest_path, output ready);
endinterface

// File: rtl/gmpl_row_mem.sv
// Row buffer memory: one write port, one registered read port, write-first on collision.
module gmpl_row_mem (
   input  logic                            clock,
   input  logic                            rd_en,
   input  logic [gmpl_pkg::COL_W-1:0]      rd_addr,
   input  logic                            wr_en,
   input  logic [gmpl_pkg::COL_W-1:0]      wr_addr,
   input  gmpl_pkg::row_entry_type         wr_data,
   output gmpl_pkg::row_entry_type         rd_data
);
   import gmpl_pkg::*;

   row_entry_type mem [MAX_COLS];
   row_entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // a read at the address being written this edge takes the new entry
   always_ff @(posedge clock) begin
      if (rd_en) begin
         if (wr_en && (wr_addr == rd_addr)) begin
            rd_data_ff <= wr_data;
         end else begin
            rd_data_ff <= mem[rd_addr];
         end
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/gmpl_seq.sv
// Grid size registers and row/column position counters.
module gmpl_seq (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_we,
   input  logic [gmpl_pkg::CSR_IDX_W-1:0]    csr_idx,
   input  logic [gmpl_pkg::CFG_W-1:0]        csr_wdata,
   input  logic                              advance,
   output gmpl_pkg::cell_pos_type            pos
);
   import gmpl_pkg::*;

   logic [CFG_W-1:0] rows_ff, rows_in;
   logic [CFG_W-1:0] cols_ff, cols_in;
   logic [COL_W-1:0] col_ff, col_in;
   logic [ROW_W-1:0] row_ff, row_in;
   logic [CFG_W-1:0] n_rows, n_cols;
   logic             row_last, col_last;

   always_comb begin
      rows_in = rows_ff;
      cols_in = cols_ff;
      if (csr_we) begin
         case (csr_idx)
            CSR_ROWS_IN_USE: rows_in = csr_wdata;
            CSR_COLS_IN_USE: cols_in = csr_wdata;
            default: ;
         endcase
      end
   end

   assign n_rows = clamp_size(rows_ff, CFG_MAX_ROWS);
   assign n_cols = clamp_size(cols_ff, CFG_MAX_COLS);

   // counters may sit beyond a size that shrank; the compare ends the row there
   assign col_last = (CFG_W'(col_ff) + CFG_W'(1)) >= n_cols;
   assign row_last = (CFG_W'(row_ff) + CFG_W'(1)) >= n_rows;

   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (advance) begin
         if (col_last) begin
            col_in = '0;
            row_in = row_last ? '0 : row_ff + ROW_W'(1);
         end else begin
            col_in = col_ff + COL_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rows_ff <= CFG_MAX_ROWS;
         cols_ff <= CFG_MAX_COLS;
         col_ff  <= '0;
         row_ff  <= '0;
      end else begin
         rows_ff <= rows_in;
         cols_ff <= cols_in;
         col_ff  <= col_in;
         row_ff  <= row_in;
      end
   end

   assign pos.slot      = col_ff;
   assign pos.has_left  = (col_ff != '0);
   assign pos.has_above = (row_ff != '0);
   assign pos.grid_end  = col_last && row_last;

endmodule

// File: rtl/grid_monotone_path_length_top.sv
// Top level: cell intake, row buffer lookup, path length compute and result register.
//
//  channel   dir  handshake           payload
//  req_ch    in   valid/ready         cell_value   (32-bit signed, row-major)
//  rsp_ch    out  valid/ready         longest_path (7-bit, once per grid)
//  csr_*     in   csr_we              csr_idx, csr_wdata (write only)
//
// One cell per cycle while intake is not stalled: the row buffer read is issued as a
// cell is taken and its data meets the cell in the compute stage in the next cycle.
// A result is loaded into the result register when the last cell of a grid leaves the compute stage.
// Synchronous reset clears counters, sizes (to 64 x 64), the running maximum and
// the result valid flag.
// Intake stalls only while the last cell of a grid waits on a held result.
module grid_monotone_path_length_top (
   input  logic                              clock,
   input  logic                              reset,
   gmpl_req_if.sink                          req_ch,
   gmpl_rsp_if.source                        rsp_ch,
   input  logic                              csr_we,
   input  logic [gmpl_pkg::CSR_IDX_W-1:0]    csr_idx,
   input  logic [gmpl_pkg::CFG_W-1:0]        csr_wdata
);
   import gmpl_pkg::*;

   cell_pos_type            pos;
   logic                    accept;
   logic                    advance;

   logic                    s1_valid_ff, s1_valid_in;
   cell_pos_type            s1_pos_ff;
   logic signed [VAL_W-1:0] s1_value_ff;

   logic signed [VAL_W-1:0] left_value_ff, left_value_in;
   logic [LEN_W-1:0]        left_length_ff, left_length_in;
   logic [LEN_W-1:0]        best_ff, best_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [LEN_W-1:0]        rsp_data_ff, rsp_data_in;

   row_entry_type           above;
   row_entry_type           wr_entry;
   logic [LEN_W-1:0]        len, cand_left, cand_above, best_next;

   assign advance = s1_valid_ff && !(s1_pos_ff.grid_end && rsp_valid_ff && !rsp_ch.ready);
   assign req_ch.ready = !s1_valid_ff || advance;
   assign accept = req_ch.valid && req_ch.ready;

   gmpl_seq u_seq (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_idx   (csr_idx),
      .csr_wdata (csr_wdata),
      .advance   (accept),
      .pos       (pos)
   );

   gmpl_row_mem u_row_mem (
      .clock   (clock),
      .rd_en   (accept),
      .rd_addr (pos.slot),
      .wr_en   (advance),
      .wr_addr (s1_pos_ff.slot),
      .wr_data (wr_entry),
      .rd_data (above)
   );

   // length of the path ending at this cell
   always_comb begin
      cand_left  = inc_sat(left_length_ff);
      cand_above = inc_sat(above.length);
      len = LEN_ONE;
      if (s1_pos_ff.has_left && (left_value_ff < s1_value_ff) && (cand_left > len)) begin
         len = cand_left;
      end
      if (s1_pos_ff.has_above && (above.value < s1_value_ff) && (cand_above > len)) begin
         len = cand_above;
      end
      best_next = (len > best_ff) ? len : best_ff;
      wr_entry.value  = s1_value_ff;
      wr_entry.length = len;
   end

   always_comb begin
      s1_valid_in    = accept || (s1_valid_ff && !advance);
      left_value_in  = left_value_ff;
      left_length_in = left_length_ff;
      best_in        = best_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ch.ready;
      rsp_data_in    = rsp_data_ff;
      if (advance) begin
         if (s1_pos_ff.grid_end) begin
            left_value_in  = '0;
            left_length_in = '0;
            best_in        = '0;
            rsp_valid_in   = 1'b1;
            rsp_data_in    = best_next;
         end else begin
            left_value_in  = s1_value_ff;
            left_length_in = len;
            best_in        = best_next;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff    <= 1'b0;
         left_value_ff  <= '0;
         left_length_ff <= '0;
         best_ff        <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         s1_valid_ff    <= s1_valid_in;
         left_value_ff  <= left_value_in;
         left_length_ff <= left_length_in;
         best_ff        <= best_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_pos_ff   <= pos;
         s1_value_ff <= req_ch.cell_value;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.longest_path = rsp_data_ff;

`ifndef ASSERT_OFF
   a_stall_holds_cell: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !advance) |=> (s1_valid_ff && $stable(s1_value_ff)))
      else $error("compute stage lost a stalled cell");

   a_grid_end_result: assert property (@(posedge clock) disable iff (reset)
      (advance && s1_pos_ff.grid_end) |=> (rsp_valid_ff && (best_ff == '0)))
      else $error("grid end did not load a result and clear the maximum");

   a_result_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_data_ff != '0))
      else $error("result path length is zero");

   a_no_intake_when_blocked: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !advance) |-> !req_ch.ready)
      else $error("cell taken while compute stage is stalled");
`endif

endmodule

// File: tb/grid_monotone_path_length_top_test.sv
// Self-checking testbench for the grid monotone path length block.
module grid_monotone_path_length_top_test;
   import gmpl_pkg::*;

   localparam int DRAIN_CYCLES = 4;
   localparam int TAIL_CYCLES  = 8;
   localparam int STALL_LIMIT  = 2000;
   localparam int PHASE_CELLS  = 250;
   localparam int SCRIPT_LEN   = 32;

   localparam logic signed [VAL_W-1:0] VAL_MIN = {1'b1, {(VAL_W-1){1'b0}}};
   localparam logic signed [VAL_W-1:0] VAL_MAX = {1'b0, {(VAL_W-1){1'b1}}};

   typedef enum logic {STEP_CELL, STEP_CSR} step_kind_type;

   typedef struct packed {
      step_kind_type           kind;
      logic [CSR_IDX_W-1:0]    idx;
      logic [CFG_W-1:0]        cfg;
      logic signed [VAL_W-1:0] value;
      logic                    typed;
      logic [LEN_W-1:0]        want;
   } script_row_type;

   logic                 clock;
   logic                 reset;
   logic                 csr_we;
   logic [CSR_IDX_W-1:0] csr_idx;
   logic [CFG_W-1:0]     csr_wdata;

   gmpl_req_if req_ch();
   gmpl_rsp_if rsp_ch();

   grid_monotone_path_length_top dut (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .rsp_ch    (rsp_ch),
      .csr_we    (csr_we),
      .csr_idx   (csr_idx),
      .csr_wdata (csr_wdata)
   );

   // path length predictor state
   logic [CFG_W-1:0]        rows_reg;
   logic [CFG_W-1:0]        cols_reg;
   logic signed [VAL_W-1:0] above_val [MAX_COLS];
   logic [LEN_W-1:0]        above_len [MAX_COLS];
   logic signed [VAL_W-1:0] left_val;
   logic [LEN_W-1:0]        left_len;
   int unsigned             col_pos;
   int unsigned             row_pos;
   logic [LEN_W-1:0]        grid_best;

   logic [LEN_W-1:0] pending_lengths [$];
   logic [LEN_W-1:0] expected_len;
   int mismatches;
   int snd_idle_pct;
   int rcv_idle_pct;
   int idle_count;
   int cells_sent;

   script_row_type script [SCRIPT_LEN] = '{
      // degenerate 1x1 grids: zero sizes act as one
      '{STEP_CSR,  CSR_ROWS_IN_USE, 7'd0, '0, 1'b0, '0},
      '{STEP_CSR,  CSR_COLS_IN_USE, 7'd0, '0, 1'b0, '0},
      '{STEP_CELL, '0, '0, VAL_MIN, 1'b1, 7'd1},
      '{STEP_CELL, '0, '0, VAL_MAX, 1'b1, 7'd1},
      // single row, strictly increasing up to the largest value
      '{STEP_CSR,  CSR_ROWS_IN_USE, 7'd1, '0, 1'b0, '0},
      '{STEP_CSR,  CSR_COLS_IN_USE, 7'd4, '0, 1'b0, '0},
      '{STEP_CELL, '0, '0, -32'sd1, 1'b0, '0},
      '{STEP_CELL, '0, '0, 32'sd0, 1'b0, '0},
      '{STEP_CELL, '0, '0, 32'sd5, 1'b0, '0},
      '{STEP_CELL, '0, '0, VAL_MAX, 1'b1, 7'd4},
      // decreasing and equal neighbors never extend a path
      '{STEP_CSR,  CSR_COLS_IN_USE, 7'd5, '0, 1'b0, '0},
      '{STEP_CELL, '0, '0, 32'sd9, 1'b0, '0},
      '{STEP_CELL, '0, '0, 32'sd7, 1'b0, '0},
      '{STEP_CELL, '0, '0, 32'sd7, 1'b0, '0},
      '{STEP_CELL, '0, '0, -32'sd3, 1'b0, '0},
      '{STEP_CELL, '0, '0, VAL_MIN, 1'b1, 7'd1},
      // 2x2: left and upper neighbors both qualify
      '{STEP_CSR,  CSR_ROWS_IN_USE, 7'd2, '0, 1'b0, '0},
      '{STEP_CSR,  CSR_COLS_IN_USE, 7'd2, '0, 1'b0, '0},
      '{STEP_CELL, '0, '0, 32'sd1, 1'b0, '0},
      '{STEP_CELL, '0, '0, 32'sd2, 1'b0, '0},
      '{STEP_CELL, '0, '0, 32'sd3, 1'b0, '0},
      '{STEP_CELL, '0, '0, 32'sd4, 1'b1, 7'd3},
      // sizes shrink mid-grid: row and grid end early
      '{STEP_CSR,  CSR_ROWS_IN_USE, 7'd3, '0, 1'b0, '0},
      '{STEP_CSR,  CSR_COLS_IN_USE, 7'd4, '0, 1'b0, '0},
      '{STEP_CELL, '0, '0, 32'sd1, 1'b0, '0},
      '{STEP_CELL, '0, '0, 32'sd2, 1'b0, '0},
      '{STEP_CELL, '0, '0, 32'sd3, 1'b0, '0},
      '{STEP_CSR,  CSR_COLS_IN_USE, 7'd2, '0, 1'b0, '0},
      '{STEP_CELL, '0, '0, 32'sd4, 1'b0, '0},
      '{STEP_CELL, '0, '0, 32'sd5, 1'b0, '0},
      '{STEP_CSR,  CSR_ROWS_IN_USE, 7'd1, '0, 1'b0, '0},
      '{STEP_CELL, '0, '0, 32'sd6, 1'b0, '0}
   };

   always begin
      clock = 1'b0;
      #2;
      clock = 1'b1;
      #2;
   end

   function automatic int unsigned eff_size(input logic [CFG_W-1:0] r, input int unsigned lim);
      if (r == '0) begin
         return 1;
      end
      return (r > lim) ? lim : r;
   endfunction

   function automatic void predict_cell(input logic signed [VAL_W-1:0] v,
                                        output bit grid_done,
                                        output logic [LEN_W-1:0] result);
      int unsigned slot;
      logic [LEN_W-1:0] len;
      logic [LEN_W-1:0] via;
      slot = (col_pos >= MAX_COLS) ? MAX_COLS - 1 : col_pos;
      len = LEN_ONE;
      grid_done = 1'b0;
      result = '0;
      if (col_pos > 0 && left_val < v) begin
         via = (left_len == '1) ? left_len : left_len + 1'b1;
         if (via > len) len = via;
      end
      if (row_pos > 0 && above_val[slot] < v) begin
         via = (above_len[slot] == '1) ? above_len[slot] : above_len[slot] + 1'b1;
         if (via > len) len = via;
      end
      above_val[slot] = v;
      above_len[slot] = len;
      left_val = v;
      left_len = len;
      if (len > grid_best) grid_best = len;
      if (col_pos + 1 >= eff_size(cols_reg, MAX_COLS)) begin
         col_pos = 0;
         if (row_pos + 1 >= eff_size(rows_reg, MAX_ROWS)) begin
            grid_done = 1'b1;
            result = grid_best;
            row_pos = 0;
            grid_best = '0;
            left_val = '0;
            left_len = '0;
         end else begin
            row_pos++;
         end
      end else begin
         col_pos++;
      end
   endfunction

   task automatic send_cell(input logic signed [VAL_W-1:0] v, output bit grid_done,
                            output logic [LEN_W-1:0] result);
      while ($urandom_range(99) < snd_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.cell_value <= v;
      do begin
         @(posedge clock);
      end while (!req_ch.ready);
      predict_cell(v, grid_done, result);
   endtask

   // block is quiet once all results are back and the pipeline has flushed
   task automatic wait_drained();
      req_ch.valid <= 1'b0;
      while (pending_lengths.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
      csr_we <= 1'b1;
      csr_idx <= idx;
      csr_wdata <= data;
      @(posedge clock);
      csr_we <= 1'b0;
      @(posedge clock);
      if (idx == CSR_ROWS_IN_USE) begin
         rows_reg = data;
      end else begin
         cols_reg = data;
      end
   endtask

   task automatic run_grid(input bit fresh);
      int unsigned pick;
      int unsigned mode;
      int nrows;
      int ncols;
      int base;
      logic [CFG_W-1:0] rsel;
      logic [CFG_W-1:0] csel;
      logic signed [VAL_W-1:0] v;
      bit grid_done;
      logic [LEN_W-1:0] result;
      if (fresh || $urandom_range(1) == 0) begin
         pick = $urandom_range(99);
         if (pick < 4) begin
            rsel = $urandom_range(1) ? CFG_MAX_ROWS : CFG_W'($urandom_range(65, 127));
            csel = CFG_W'($urandom_range(2));
         end else if (pick < 8) begin
            rsel = CFG_W'($urandom_range(2));
            csel = $urandom_range(1) ? CFG_MAX_COLS : CFG_W'($urandom_range(65, 127));
         end else begin
            rsel = CFG_W'($urandom_range(8));
            csel = CFG_W'($urandom_range(8));
         end
         wait_drained();
         write_csr(CSR_ROWS_IN_USE, rsel);
         write_csr(CSR_COLS_IN_USE, csel);
      end
      nrows = eff_size(rows_reg, MAX_ROWS);
      ncols = eff_size(cols_reg, MAX_COLS);
      mode = $urandom_range(3);
      base = int'($urandom_range(2000)) - 1000;
      for (int r = 0; r < nrows; r++) begin
         for (int c = 0; c < ncols; c++) begin
            case (mode)
               0: v = $urandom;
               1: v = $urandom_range(7);
               // mostly rising ramp gives long paths; an occasional outlier breaks it
               2: v = ($urandom_range(9) == 0) ? $urandom : base + 4 * (r + c) + $urandom_range(3);
               default: begin
                  case ($urandom_range(4))
                     0: v = VAL_MIN;
                     1: v = VAL_MAX;
                     2: v = -1;
                     3: v = 0;
                     default: v = 1;
                  endcase
               end
            endcase
            send_cell(v, grid_done, result);
            if (grid_done) pending_lengths.push_back(result);
            cells_sent++;
         end
      end
   endtask

   // result side: random backpressure and in-order compare per transaction
   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (pending_lengths.size() == 0) begin
               $display("%0t: longest_path expected none, got %0d", $time, rsp_ch.longest_path);
               mismatches++;
            end else begin
               expected_len = pending_lengths.pop_front();
               if (rsp_ch.longest_path !== expected_len) begin
                  $display("%0t: longest_path expected %0d, got %0d", $time, expected_len,
                           rsp_ch.longest_path);
                  mismatches++;
               end
            end
         end
         rsp_ch.ready <= ($urandom_range(99) >= rcv_idle_pct);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
         idle_count <= 0;
      end else if (idle_count >= STALL_LIMIT) begin
         $display("grid_monotone_path_length_top verification failed");
         $finish;
      end else begin
         idle_count <= idle_count + 1;
      end
   end

   initial begin
      bit grid_done;
      bit first;
      logic [LEN_W-1:0] result;
      reset = 1'b1;
      csr_we = 1'b0;
      csr_idx = '0;
      csr_wdata = '0;
      req_ch.valid = 1'b0;
      req_ch.cell_value = '0;
      rsp_ch.ready = 1'b0;
      rows_reg = CFG_MAX_ROWS;
      cols_reg = CFG_MAX_COLS;
      left_val = '0;
      left_len = '0;
      col_pos = 0;
      row_pos = 0;
      grid_best = '0;
      mismatches = 0;
      idle_count = 0;
      cells_sent = 0;
      snd_idle_pct = 21;
      rcv_idle_pct = 59;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      foreach (script[i]) begin
         if (script[i].kind == STEP_CSR) begin
            wait_drained();
            write_csr(script[i].idx, script[i].cfg);
         end else begin
            send_cell(script[i].value, grid_done, result);
            if (script[i].typed) begin
               pending_lengths.push_back(script[i].want);
            end else if (grid_done) begin
               pending_lengths.push_back(result);
            end
         end
      end

      for (int phase = 0; phase < 3; phase++) begin
         case (phase)
            0: begin
               snd_idle_pct = 21;
               rcv_idle_pct = 59;
            end
            1: begin
               snd_idle_pct = 59;
               rcv_idle_pct = 21;
            end
            default: begin
               snd_idle_pct = 0;
               rcv_idle_pct = 0;
            end
         endcase
         cells_sent = 0;
         first = 1'b1;
         while (cells_sent < PHASE_CELLS) begin
            run_grid(first);
            first = 1'b0;
         end
      end

      req_ch.valid <= 1'b0;
      while (pending_lengths.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatches == 0) begin
         $display("grid_monotone_path_length_top verification clean");
      end else begin
         $display("grid_monotone_path_length_top verification failed");
      end
      $finish;
   end

endmodule

// File: sim.f
rtl/gmpl_pkg.sv
rtl/gmpl_if.sv
rtl/gmpl_row_mem.sv
rtl/gmpl_seq.sv
rtl/grid_monotone_path_length_top.sv
tb/grid_monotone_path_length_top_test.sv
